// File: hdl/dscs_pkg.sv
package dscs_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_MATCH_NEEDED = 2'd0;
  localparam logic [1:0] CFG_RESEND_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_CYCLE_PERIOD = 2'd2;

  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth = 24;

  // reset values of the registers
  localparam logic [3:0] MATCH_NEEDED_RST = 4'd3;
  localparam logic [23:0] RESEND_TIMEOUT_RST = 24'd20000;
  localparam logic [15:0] CYCLE_PERIOD_RST = 16'd1000;

  localparam logic [23:0] TIMER_MAX = 24'hFFFFFF;
  localparam logic [3:0] MATCH_COUNT_MAX = 4'd15;

  // item kinds
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_CYCLE = 1'b1;

  // drive states
  localparam logic [2:0] ST_OFF_DISABLED = 3'd0;
  localparam logic [2:0] ST_READY = 3'd1;
  localparam logic [2:0] ST_SWITCHED_ON = 3'd2;
  localparam logic [2:0] ST_ENABLED = 3'd3;
  localparam logic [2:0] ST_QUICKSTOP = 3'd4;
  localparam logic [2:0] ST_FAULT = 3'd5;

  // controlwords
  localparam logic [15:0] CW_DISABLE_VOLTAGE = 16'h0000;
  localparam logic [15:0] CW_QUICK_STOP = 16'h0002;
  localparam logic [15:0] CW_SHUTDOWN = 16'h0006;
  localparam logic [15:0] CW_SWITCH_ON = 16'h0007;
  localparam logic [15:0] CW_ENABLE_OP = 16'h000F;
  localparam logic [15:0] CW_FAULT_RESET = 16'h0080;

  typedef struct packed {
    logic [3:0]  match_needed;
    logic [23:0] resend_timeout;
    logic [15:0] cycle_period;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic [2:0] requested_state;
    logic [2:0] present_state;
  } step_in_t;

  typedef struct packed {
    logic [15:0] controlword;
    logic        controlword_sent;
    logic        change_succeeded;
    logic        change_active;
  } step_out_t;

  // next controlword toward target from present state
  function automatic logic [15:0] next_cw(input logic [2:0] target, input logic [2:0] present);
    logic [15:0] cw;
    cw = CW_DISABLE_VOLTAGE;
    if (present == ST_FAULT) begin
      if (target == ST_OFF_DISABLED || target == ST_READY || target == ST_SWITCHED_ON ||
          target == ST_ENABLED || target == ST_QUICKSTOP) begin
        cw = CW_FAULT_RESET;
      end
    end else begin
      case (target)
        ST_READY: begin
          if (present == ST_OFF_DISABLED || present == ST_SWITCHED_ON ||
              present == ST_ENABLED) begin
            cw = CW_SHUTDOWN;
          end
        end
        ST_SWITCHED_ON: begin
          if (present == ST_OFF_DISABLED) cw = CW_SHUTDOWN;
          else if (present == ST_READY || present == ST_ENABLED) cw = CW_SWITCH_ON;
        end
        ST_ENABLED: begin
          if (present == ST_OFF_DISABLED) cw = CW_SHUTDOWN;
          else if (present == ST_READY) cw = CW_SWITCH_ON;
          else if (present == ST_SWITCHED_ON) cw = CW_ENABLE_OP;
        end
        ST_QUICKSTOP: begin
          if (present == ST_OFF_DISABLED) cw = CW_SHUTDOWN;
          else if (present == ST_READY) cw = CW_SWITCH_ON;
          else if (present == ST_SWITCHED_ON) cw = CW_ENABLE_OP;
          else if (present == ST_ENABLED) cw = CW_QUICK_STOP;
        end
        default: cw = CW_DISABLE_VOLTAGE;
      endcase
    end
    return cw;
  endfunction

endpackage

// File: hdl/dscs_cfg.sv
module dscs_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [dscs_pkg::CfgIndexWidth-1:0] wr_index,
  input  logic [dscs_pkg::CfgDataWidth-1:0]  wr_data,
  output dscs_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_needed <= dscs_pkg::MATCH_NEEDED_RST;
      cfg.resend_timeout <= dscs_pkg::RESEND_TIMEOUT_RST;
      cfg.cycle_period <= dscs_pkg::CYCLE_PERIOD_RST;
    end else if (wr_en) begin
      case (wr_index)
        dscs_pkg::CFG_MATCH_NEEDED: cfg.match_needed <= wr_data[3:0];
        dscs_pkg::CFG_RESEND_TIMEOUT: cfg.resend_timeout <= wr_data[23:0];
        dscs_pkg::CFG_CYCLE_PERIOD: cfg.cycle_period <= wr_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/dscs_step.sv
module dscs_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  dscs_pkg::step_in_t   item,
  input  dscs_pkg::cfg_t       cfg,
  output dscs_pkg::step_out_t  result
);

  logic [2:0]  target_state;
  logic [3:0]  match_count;
  logic [23:0] elapsed_us;
  logic        success_flag;
  logic        active_flag;

  logic [2:0]  target_state_next;
  logic [3:0]  match_count_next;
  logic [23:0] elapsed_us_next;
  logic        success_flag_next;
  logic        active_flag_next;

  logic [24:0] elapsed_sum;
  logic [23:0] elapsed_sat;
  logic [3:0]  match_inc;

  always_comb begin
    elapsed_sum = {1'b0, elapsed_us} + {9'd0, cfg.cycle_period};
    elapsed_sat = elapsed_sum[24] ? dscs_pkg::TIMER_MAX : elapsed_sum[23:0];
    match_inc = (match_count < dscs_pkg::MATCH_COUNT_MAX) ? match_count + 4'd1 : match_count;

    target_state_next = target_state;
    match_count_next = match_count;
    elapsed_us_next = elapsed_us;
    success_flag_next = success_flag;
    active_flag_next = active_flag;
    result.controlword = dscs_pkg::CW_DISABLE_VOLTAGE;
    result.controlword_sent = 1'b0;

    if (item.cmd == dscs_pkg::CMD_REQUEST) begin
      target_state_next = item.requested_state;
      success_flag_next = 1'b0;
      active_flag_next = 1'b1;
      elapsed_us_next = '0;
    end else begin
      elapsed_us_next = elapsed_sat;
      if (item.present_state == target_state) begin
        if (match_inc >= cfg.match_needed) begin
          match_count_next = '0;
          success_flag_next = 1'b1;
          active_flag_next = 1'b0;
        end else begin
          match_count_next = match_inc;
        end
      end else if (elapsed_sat > cfg.resend_timeout) begin
        result.controlword = dscs_pkg::next_cw(target_state, item.present_state);
        result.controlword_sent = 1'b1;
        elapsed_us_next = '0;
      end
    end

    result.change_succeeded = success_flag_next;
    result.change_active = active_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_state <= '0;
      match_count <= '0;
      elapsed_us <= '0;
      success_flag <= 1'b0;
      active_flag <= 1'b0;
    end else if (advance) begin
      target_state <= target_state_next;
      match_count <= match_count_next;
      elapsed_us <= elapsed_us_next;
      success_flag <= success_flag_next;
      active_flag <= active_flag_next;
    end
  end

endmodule

// File: hdl/drive_state_controlword_sequencer.sv
// steers a cia 402 drive toward a requested state. a request (s_tuser 0) stores the
// target and restarts the change; a cycle item (s_tuser 1) carries the drive state just
// read, advances the resend timer by the cycle period and either counts a matching
// reading or, once the timer passes the resend timeout, emits the next controlword of
// the transition path. every item gives exactly one result. the block takes one item
// per clock unless stalled: an item sits in the input register, the next-state logic and
// controlword table settle combinationally and the result lands in the output register,
// where m_tvalid rises. the input register can still take an item while a result waits
// on m_tready, and stalls only when both registers are full and m_tready is low.
// registers are written through the cfg port (index 0 match readings needed, 1 resend
// timeout in microseconds, index 2 the cycle period in microseconds); the user must
// write them only while no item is in flight, the block itself does not enforce it.
module drive_state_controlword_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  // request input
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // requested_state[2:0], present_state[5:3]
  input  logic [0:0]                          s_tuser,   // cmd[0]
  // result output
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [23:0]                         m_tdata,   // controlword[15:0], change_succeeded[16],
                                                         // change_active[17]
  output logic [0:0]                          m_tuser,   // controlword_sent[0]
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dscs_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [dscs_pkg::CfgDataWidth-1:0]  cfg_data
);

  dscs_pkg::cfg_t      cfg;
  dscs_pkg::step_in_t  in_item;
  dscs_pkg::step_out_t step_result;
  dscs_pkg::step_out_t out_item;
  logic                in_valid;
  logic                out_valid;
  logic                advance;
  logic                s_accept;

  // registers accept a write every cycle
  assign cfg_ready = 1'b1;

  dscs_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // move the held request into the output register when it is free or draining
  assign advance = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_item.cmd <= s_tuser[0];
      in_item.requested_state <= s_tdata[2:0];
      in_item.present_state <= s_tdata[5:3];
    end
  end

  // state update and controlword lookup
  dscs_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {6'd0, out_item.change_active, out_item.change_succeeded,
                    out_item.controlword};
  assign m_tuser = out_item.controlword_sent;

endmodule

// File: hdl/dscs_checker.sv
module dscs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // no controlword value without the sent flag
  a_idle_cw_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[15:0] == dscs_pkg::CW_DISABLE_VOLTAGE)
    else $error("controlword nonzero without sent flag");

  // a sent controlword is one the transition table can produce
  a_cw_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      m_tdata[15:0] == dscs_pkg::CW_DISABLE_VOLTAGE ||
      m_tdata[15:0] == dscs_pkg::CW_QUICK_STOP ||
      m_tdata[15:0] == dscs_pkg::CW_SHUTDOWN || m_tdata[15:0] == dscs_pkg::CW_SWITCH_ON ||
      m_tdata[15:0] == dscs_pkg::CW_ENABLE_OP || m_tdata[15:0] == dscs_pkg::CW_FAULT_RESET)
    else $error("controlword outside the transition table");

  // success and an active change never show together
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[16] && m_tdata[17]))
    else $error("success and active both set");

  // leaving reset, no result is shown and requests are taken
  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("bad state after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind drive_state_controlword_sequencer dscs_checker u_dscs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: sim/testbench.sv
module testbench;

  // state codes the package leaves unnamed
  localparam logic [2:0] ST_OTHER = 3'd6;
  localparam logic [2:0] ST_CODE7 = 3'd7;

  // watchdog, far above the slowest legal run
  localparam int CYCLE_LIMIT = 200000;
  // cycles allowed after the last result before a register write or the end
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS = 30;

  // every request item answers with no controlword, success cleared, change active
  localparam dscs_pkg::step_out_t AFTER_REQUEST = '{controlword: 16'h0000,
                                                    controlword_sent: 1'b0,
                                                    change_succeeded: 1'b0,
                                                    change_active: 1'b1};

  // one line of the directed plan: a register write or an item
  typedef struct {
    bit                                 is_cfg;
    logic [dscs_pkg::CfgIndexWidth-1:0] reg_index;
    logic [dscs_pkg::CfgDataWidth-1:0]  reg_value;
    logic                               cmd;
    logic [2:0]                         req_state;
    logic [2:0]                         pres_state;
    bit                                 typed;
    dscs_pkg::step_out_t                want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [7:0]                         s_tdata = '0;   // requested_state[2:0], present_state[5:3]
  logic [0:0]                         s_tuser = '0;   // cmd[0]
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [23:0]                        m_tdata;        // controlword[15:0], change_succeeded[16],
                                                      // change_active[17]
  logic [0:0]                         m_tuser;        // controlword_sent[0]
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [dscs_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [dscs_pkg::CfgDataWidth-1:0]  cfg_data = '0;

  drive_state_controlword_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // sequencer registers as the testbench believes them to be
  logic [3:0]  needed_q = dscs_pkg::MATCH_NEEDED_RST;
  logic [23:0] timeout_q = dscs_pkg::RESEND_TIMEOUT_RST;
  logic [15:0] period_q = dscs_pkg::CYCLE_PERIOD_RST;

  // sequencer state, all zero after reset
  logic [2:0]  target_q = '0;
  logic [3:0]  match_q = '0;
  logic [23:0] elapsed_q = '0;
  logic        success_q = 1'b0;
  logic        active_q = 1'b0;

  // results still owed by the block, oldest first
  dscs_pkg::step_out_t pending_results[$];
  dscs_pkg::step_out_t oldest_result;

  bit no_idle = 1'b0;
  int cycle_count = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int controlwords_sent = 0;
  int successes_declared = 0;
  int register_writes = 0;
  plan_row_t plan[$];

  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // next controlword on the cia 402 path from the present state toward the target
  function automatic logic [15:0] transition_cw(input logic [2:0] target,
                                                input logic [2:0] present);
    logic [15:0] cw;
    cw = dscs_pkg::CW_DISABLE_VOLTAGE;
    // fault, other and code 7 targets, and unknown readings, fall back to 0
    if (target <= dscs_pkg::ST_QUICKSTOP) begin
      if (present == dscs_pkg::ST_FAULT) begin
        cw = dscs_pkg::CW_FAULT_RESET;
      end else begin
        case (target)
          dscs_pkg::ST_READY: begin
            if (present == dscs_pkg::ST_OFF_DISABLED || present == dscs_pkg::ST_SWITCHED_ON ||
                present == dscs_pkg::ST_ENABLED) cw = dscs_pkg::CW_SHUTDOWN;
          end
          dscs_pkg::ST_SWITCHED_ON: begin
            if (present == dscs_pkg::ST_OFF_DISABLED) cw = dscs_pkg::CW_SHUTDOWN;
            if (present == dscs_pkg::ST_READY || present == dscs_pkg::ST_ENABLED)
              cw = dscs_pkg::CW_SWITCH_ON;
          end
          dscs_pkg::ST_ENABLED, dscs_pkg::ST_QUICKSTOP: begin
            if (present == dscs_pkg::ST_OFF_DISABLED) cw = dscs_pkg::CW_SHUTDOWN;
            if (present == dscs_pkg::ST_READY) cw = dscs_pkg::CW_SWITCH_ON;
            if (present == dscs_pkg::ST_SWITCHED_ON) cw = dscs_pkg::CW_ENABLE_OP;
            // only the quickstop target leaves operation enabled by a quick stop
            if (target == dscs_pkg::ST_QUICKSTOP && present == dscs_pkg::ST_ENABLED)
              cw = dscs_pkg::CW_QUICK_STOP;
          end
          default: cw = dscs_pkg::CW_DISABLE_VOLTAGE;
        endcase
      end
    end
    return cw;
  endfunction

  // advances the sequencer state by one item and returns its result
  function automatic dscs_pkg::step_out_t sequencer_step(input logic cmd,
                                                         input logic [2:0] req,
                                                         input logic [2:0] pres);
    dscs_pkg::step_out_t res;
    logic [24:0] sum;
    res = '0;
    if (cmd == dscs_pkg::CMD_REQUEST) begin
      target_q = req;
      success_q = 1'b0;
      active_q = 1'b1;
      elapsed_q = '0;
    end else begin
      // saturating timer
      sum = {1'b0, elapsed_q} + {9'd0, period_q};
      elapsed_q = sum[24] ? dscs_pkg::TIMER_MAX : sum[23:0];
      if (pres == target_q) begin
        if (match_q < dscs_pkg::MATCH_COUNT_MAX) match_q = match_q + 4'd1;
        if (match_q >= needed_q) begin
          match_q = '0;
          success_q = 1'b1;
          active_q = 1'b0;
          successes_declared++;
        end
      end else if (elapsed_q > timeout_q) begin
        // a mismatch keeps the match count as it is
        res.controlword = transition_cw(target_q, pres);
        res.controlword_sent = 1'b1;
        elapsed_q = '0;
      end
    end
    res.change_succeeded = success_q;
    res.change_active = active_q;
    return res;
  endfunction

  function automatic plan_row_t plan_item(input logic cmd, input logic [2:0] req,
                                          input logic [2:0] pres);
    plan_row_t row;
    row = '{default: '0};
    row.cmd = cmd;
    row.req_state = req;
    row.pres_state = pres;
    return row;
  endfunction

  function automatic plan_row_t plan_typed(input logic cmd, input logic [2:0] req,
                                           input logic [2:0] pres,
                                           input dscs_pkg::step_out_t want);
    plan_row_t row;
    row = plan_item(cmd, req, pres);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic plan_row_t plan_cfg(input logic [dscs_pkg::CfgIndexWidth-1:0] idx,
                                         input logic [dscs_pkg::CfgDataWidth-1:0] value);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_index = idx;
    row.reg_value = value;
    return row;
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h", results_checked, what,
               got, want);
    end
  endtask

  // one item request, after a random gap; the expectation is queued at acceptance
  task automatic send_item(input logic cmd, input logic [2:0] req, input logic [2:0] pres,
                           input bit typed, input dscs_pkg::step_out_t want);
    int gap;
    dscs_pkg::step_out_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {2'b00, pres, req};
    do @(posedge clk); while (!s_tready);
    predicted = sequencer_step(cmd, req, pres);
    if (predicted.controlword_sent) controlwords_sent++;
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // stop sending and wait until the block has answered everything
  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [dscs_pkg::CfgIndexWidth-1:0] idx,
                           input logic [dscs_pkg::CfgDataWidth-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dscs_pkg::CFG_MATCH_NEEDED: needed_q = value[3:0];
      dscs_pkg::CFG_RESEND_TIMEOUT: timeout_q = value[23:0];
      dscs_pkg::CFG_CYCLE_PERIOD: period_q = value[15:0];
      default: ;
    endcase
    register_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly readings of the target or random states, some new targets, a few code 7
  task automatic random_item(input bit allow_target_change);
    logic cmd;
    logic [2:0] req;
    logic [2:0] pres;
    int pick;
    cmd = (allow_target_change && $urandom_range(0, 99) < 15) ? dscs_pkg::CMD_REQUEST :
                                                                 dscs_pkg::CMD_CYCLE;
    req = ($urandom_range(0, 9) == 0) ? ST_CODE7 : 3'($urandom_range(0, 6));
    pick = $urandom_range(0, 9);
    if (pick < 5) pres = target_q;
    else if (pick < 9) pres = 3'($urandom_range(0, 6));
    else pres = ST_CODE7;
    send_item(cmd, req, pres, 1'b0, AFTER_REQUEST);
  endtask

  // registers written with the block idle, then a burst of random items
  task automatic run_phase(input logic [3:0] needed, input logic [23:0] timeout,
                           input logic [15:0] period, input int count,
                           input bit allow_target_change);
    settle_block();
    cfg_write(dscs_pkg::CFG_MATCH_NEEDED, {20'd0, needed});
    cfg_write(dscs_pkg::CFG_RESEND_TIMEOUT, timeout);
    cfg_write(dscs_pkg::CFG_CYCLE_PERIOD, {8'd0, period});
    no_idle = ($urandom_range(0, 3) == 0);
    repeat (count) random_item(allow_target_change);
  endtask

  // result side: random stall before each result, none when no_idle is set
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // every accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", m_tdata, 24'd0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_tdata[15:0] !== oldest_result.controlword)
          report_mismatch("controlword", {8'd0, m_tdata[15:0]},
                          {8'd0, oldest_result.controlword});
        if (m_tuser[0] !== oldest_result.controlword_sent)
          report_mismatch("controlword_sent", {23'd0, m_tuser[0]},
                          {23'd0, oldest_result.controlword_sent});
        if (m_tdata[16] !== oldest_result.change_succeeded)
          report_mismatch("change_succeeded", {23'd0, m_tdata[16]},
                          {23'd0, oldest_result.change_succeeded});
        if (m_tdata[17] !== oldest_result.change_active)
          report_mismatch("change_active", {23'd0, m_tdata[17]},
                          {23'd0, oldest_result.change_active});
      end
    end
  end

  initial begin
    // reset values first, then a zero timeout and a unit cycle period so every mismatch sends
    plan.push_back(plan_typed(dscs_pkg::CMD_CYCLE, dscs_pkg::ST_READY,
                              dscs_pkg::ST_OFF_DISABLED,
                              '{controlword: 16'h0000, controlword_sent: 1'b0,
                                change_succeeded: 1'b0, change_active: 1'b0}));
    plan.push_back(plan_typed(dscs_pkg::CMD_REQUEST, dscs_pkg::ST_ENABLED, ST_CODE7,
                              AFTER_REQUEST));
    plan.push_back(plan_cfg(dscs_pkg::CFG_RESEND_TIMEOUT, 24'd0));
    plan.push_back(plan_cfg(dscs_pkg::CFG_CYCLE_PERIOD, 24'd1));
    // walk toward enabled from each state, then fault, other and code 7 readings
    plan.push_back(plan_item(dscs_pkg::CMD_CYCLE, ST_OTHER, dscs_pkg::ST_OFF_DISABLED));
    plan.push_back(plan_item(dscs_pkg::CMD_CYCLE, ST_CODE7, dscs_pkg::ST_READY));
    plan.push_back(plan_item(dscs_pkg::CMD_CYCLE, dscs_pkg::ST_OFF_DISABLED,
                             dscs_pkg::ST_SWITCHED_ON));
    plan.push_back(plan_item(dscs_pkg::CMD_CYCLE, dscs_pkg::ST_FAULT, dscs_pkg::ST_FAULT));
    plan.push_back(plan_item(dscs_pkg::CMD_CYCLE, dscs_pkg::ST_READY, ST_OTHER));
    plan.push_back(plan_item(dscs_pkg::CMD_CYCLE, dscs_pkg::ST_QUICKSTOP, ST_CODE7));
    // matches resume the count left over from before the request
    plan.push_back(plan_item(dscs_pkg::CMD_CYCLE, dscs_pkg::ST_SWITCHED_ON,
                             dscs_pkg::ST_ENABLED));
    plan.push_back(plan_item(dscs_pkg::CMD_CYCLE, dscs_pkg::ST_ENABLED, dscs_pkg::ST_ENABLED));
    // quick stop, then targets that have no path
    plan.push_back(plan_typed(dscs_pkg::CMD_REQUEST, dscs_pkg::ST_QUICKSTOP,
                              dscs_pkg::ST_FAULT, AFTER_REQUEST));
    plan.push_back(plan_item(dscs_pkg::CMD_CYCLE, dscs_pkg::ST_READY, dscs_pkg::ST_ENABLED));
    plan.push_back(plan_typed(dscs_pkg::CMD_REQUEST, ST_CODE7, dscs_pkg::ST_OFF_DISABLED,
                              AFTER_REQUEST));
    plan.push_back(plan_item(dscs_pkg::CMD_CYCLE, dscs_pkg::ST_OFF_DISABLED,
                             dscs_pkg::ST_FAULT));
    plan.push_back(plan_typed(dscs_pkg::CMD_REQUEST, dscs_pkg::ST_FAULT, dscs_pkg::ST_READY,
                              AFTER_REQUEST));
    plan.push_back(plan_item(dscs_pkg::CMD_CYCLE, ST_OTHER, dscs_pkg::ST_OFF_DISABLED));
    plan.push_back(plan_typed(dscs_pkg::CMD_REQUEST, ST_OTHER, dscs_pkg::ST_SWITCHED_ON,
                              AFTER_REQUEST));
    plan.push_back(plan_item(dscs_pkg::CMD_CYCLE, dscs_pkg::ST_FAULT,
                             dscs_pkg::ST_SWITCHED_ON));
    // zero readings needed: first match succeeds
    plan.push_back(plan_cfg(dscs_pkg::CFG_MATCH_NEEDED, 24'd0));
    plan.push_back(plan_typed(dscs_pkg::CMD_REQUEST, dscs_pkg::ST_READY,
                              dscs_pkg::ST_QUICKSTOP, AFTER_REQUEST));
    plan.push_back(plan_item(dscs_pkg::CMD_CYCLE, dscs_pkg::ST_SWITCHED_ON,
                             dscs_pkg::ST_READY));
    plan.push_back(plan_item(dscs_pkg::CMD_CYCLE, dscs_pkg::ST_ENABLED,
                             dscs_pkg::ST_QUICKSTOP));
    // zero cycle period: the timer never passes a zero timeout
    plan.push_back(plan_cfg(dscs_pkg::CFG_CYCLE_PERIOD, 24'd0));
    plan.push_back(plan_typed(dscs_pkg::CMD_REQUEST, dscs_pkg::ST_SWITCHED_ON,
                              dscs_pkg::ST_ENABLED, AFTER_REQUEST));
    plan.push_back(plan_typed(dscs_pkg::CMD_CYCLE, dscs_pkg::ST_READY,
                              dscs_pkg::ST_OFF_DISABLED, AFTER_REQUEST));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      no_idle = ($urandom_range(0, 2) == 0);
      if (plan[i].is_cfg) begin
        settle_block();
        cfg_write(plan[i].reg_index, plan[i].reg_value);
      end else begin
        send_item(plan[i].cmd, plan[i].req_state, plan[i].pres_state, plan[i].typed,
                  plan[i].want);
      end
    end

    // reset settings, then every mismatch sending, then slow success and random timers
    run_phase(dscs_pkg::MATCH_NEEDED_RST, dscs_pkg::RESEND_TIMEOUT_RST,
              dscs_pkg::CYCLE_PERIOD_RST, 35, 1'b1);
    run_phase(4'd1, 24'd0, 16'd1, 35, 1'b1);
    run_phase(4'd15, 24'($urandom_range(0, 5000)), 16'($urandom_range(1, 2000)), 40, 1'b1);

    // drive the timer into saturation with a timeout that can never be passed
    run_phase(4'd15, dscs_pkg::TIMER_MAX, 16'hFFFF, 260, 1'b0);
    // one below the top: the saturated timer now exceeds it
    settle_block();
    cfg_write(dscs_pkg::CFG_RESEND_TIMEOUT, dscs_pkg::TIMER_MAX - 24'd1);
    repeat (12) random_item(1'b0);

    repeat (3) begin
      run_phase(4'($urandom_range(0, 15)), 24'($urandom_range(0, 30000)),
                16'($urandom_range(1, 65535)), 25, 1'b1);
    end

    settle_block();
    $display("%0d items and %0d register writes sent, %0d results checked", items_sent,
             register_writes, results_checked);
    $display("%0d controlwords issued, %0d state changes declared successful",
             controlwords_sent, successes_declared);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
